[rtl/sele_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sele_pkg;

   localparam int LIST_DEPTH = 256;
   localparam int CODE_BITS  = 32;
   localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
   localparam int SUM_W      = LEN_W + 2;

   typedef enum logic [3:0] {
      CMD_CLEAR   = 4'd0,
      CMD_APPEND  = 4'd1,
      CMD_PREPEND = 4'd2,
      CMD_POP     = 4'd3,
      CMD_ERASE   = 4'd4,
      CMD_FIND    = 4'd5,
      CMD_READ    = 4'd6,
      CMD_SORT    = 4'd7,
      CMD_PICK    = 4'd8
   } cmd_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHUP,
      CELL_SHDN,
      CELL_ROT,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic signed [31:0]   score;
   } entry_type;

   typedef struct packed {
      cell_op_type      op;
      logic [LEN_W-1:0] wr_idx;
      logic [LEN_W-1:0] pos;
      logic [LEN_W-1:0] sort_end;
      logic             parity;
      entry_type        new_entry;
   } ctl_type;

endpackage

`default_nettype wire

[rtl/scored_entry_list_engine_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tuser: cmd; tdata: code, score, position, span
// rsp      out  rsp_tvalid/tready    tuser: out_valid; tdata: hit, code, score, length
// Short commands go through ST_FIN and ST_OUT; rsp_tvalid and req_tready rise together.
// Find and read also pass through ST_RUN for one full rotation of the cell chain; sort and
// pick-next pass through ST_RUN unless there is nothing to do, as does a shifting erase.
// One command in flight; req_tready is high only between commands.
// A result held by rsp_tready does not stop the next command being taken.
// Synchronous reset empties the list; entry contents are left as they are.

module scored_entry_list_engine_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [87:0] req_tdata,  // code[31:0], score[63:32], position[71:64], span[81:72]
   input  wire  [3:0]  req_tuser,  // cmd[3:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [87:0] rsp_tdata,  // hit_index[8:0], code[40:9], score[72:41], length[81:73]
   output logic [0:0]  rsp_tuser   // out_valid[0]
);
   import sele_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_FIN  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [3:0]       cmd_ff, cmd_in;
   entry_type        new_ff, new_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [9:0]       span_ff, span_in;
   logic [LEN_W-1:0] end_ff, end_in;
   logic [LEN_W-1:0] steps_ff, steps_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] len_ff, len_in;
   entry_type        carry_ff, carry_in;
   logic [LEN_W-1:0] hit_ff, hit_in;
   logic             found_ff, found_in;
   entry_type        out_ff, out_in;
   logic             ovalid_ff, ovalid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [87:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   ctl_type          ctl;
   entry_type        rot_in;
   entry_type        ents  [LIST_DEPTH];
   logic             swaps [LIST_DEPTH];

   logic             accept;
   logic [3:0]       req_cmd;
   logic [LEN_W-1:0] req_pos;
   logic [9:0]       req_span;
   logic [SUM_W-1:0] req_cnt, req_reach, ff_reach, len_w;
   logic [LEN_W-1:0] req_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_cmd    = req_tuser;
   assign req_pos    = LEN_W'(req_tdata[71:64]);
   assign req_span   = req_tdata[81:72];
   assign req_cnt    = SUM_W'(req_span[8:0]);
   assign len_w      = SUM_W'(len_ff);
   assign req_reach  = SUM_W'(req_pos) + req_cnt;
   assign ff_reach   = SUM_W'(pos_ff) + SUM_W'(span_ff[8:0]);
   assign req_end    = (!req_span[9] && (req_cnt < len_w)) ? LEN_W'(req_span[8:0])
                                                           : len_ff - 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      sele_cell u_cell (
         .clock  (clock),
         .idx    (LEN_W'(g)),
         .ctl    (ctl),
         .left   ((g == 0) ? ctl.new_entry : ents[(g == 0) ? 0 : g - 1]),
         .right  ((g == LIST_DEPTH - 1) ? rot_in : ents[(g == LIST_DEPTH - 1) ? g : g + 1]),
         .swap_l ((g == 0) ? 1'b0 : swaps[(g == 0) ? 0 : g - 1]),
         .swap_r (swaps[g]),
         .entry  (ents[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      new_in       = new_ff;
      pos_in       = pos_ff;
      span_in      = span_ff;
      end_in       = end_ff;
      steps_in     = steps_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      carry_in     = carry_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      out_in       = out_ff;
      ovalid_in    = ovalid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rot_in       = ents[0];
      ctl.op       = CELL_HOLD;
      ctl.wr_idx   = len_ff;
      ctl.pos      = pos_ff;
      ctl.sort_end = end_ff;
      ctl.parity   = k_ff[0];
      ctl.new_entry = new_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in          = req_cmd;
               new_in.code     = CODE_BITS'(req_tdata[31:0]);
               new_in.score    = req_tdata[63:32];
               pos_in          = req_pos;
               span_in         = req_span;
               end_in          = req_end;
               k_in            = '0;
               hit_in          = '0;
               found_in        = 1'b0;
               out_in          = '0;
               ovalid_in       = 1'b0;
               steps_in        = '0;
               priority case (req_cmd)
                  CMD_FIND: begin
                     hit_in   = len_ff;
                     steps_in = LEN_W'(LIST_DEPTH);
                  end
                  CMD_READ: steps_in = LEN_W'(LIST_DEPTH);
                  CMD_SORT: begin
                     if ((len_ff != '0) && (req_pos < req_end)) steps_in = LEN_W'(LIST_DEPTH);
                  end
                  CMD_PICK: begin
                     if (req_pos < len_ff) steps_in = LEN_W'(LIST_DEPTH);
                  end
                  CMD_ERASE: begin
                     if ((req_pos < len_ff) && !req_span[9] && (req_reach < len_w)
                         && (req_cnt != '0))
                        steps_in = LEN_W'(req_cnt);
                  end
                  default: steps_in = '0;
               endcase
               state_in = (steps_in != '0) ? ST_RUN : ST_FIN;
            end
         end
         ST_RUN: begin
            priority case (cmd_ff)
               CMD_ERASE: ctl.op = CELL_SHDN;
               CMD_SORT:  ctl.op = CELL_SORT;
               CMD_FIND: begin
                  ctl.op = CELL_ROT;
                  if (!found_ff && (k_ff < len_ff) && (ents[0].code == new_ff.code)) begin
                     hit_in   = k_ff;
                     found_in = 1'b1;
                  end
               end
               CMD_READ: begin
                  ctl.op = CELL_ROT;
                  if ((k_ff == pos_ff) && (pos_ff < len_ff)) begin
                     out_in    = ents[0];
                     ovalid_in = 1'b1;
                  end
               end
               CMD_PICK: begin
                  ctl.op = CELL_ROT;
                  if (k_ff == pos_ff) begin
                     carry_in = ents[0];
                  end else if ((k_ff > pos_ff) && (k_ff < len_ff)
                               && (ents[0].score > carry_ff.score)) begin
                     carry_in = ents[0];
                     rot_in   = carry_ff;
                  end
               end
               default: ctl.op = CELL_HOLD;
            endcase
            k_in = k_ff + 1'b1;
            if (k_ff == steps_ff - 1'b1) state_in = ST_FIN;
         end
         ST_FIN: begin
            priority case (cmd_ff)
               CMD_CLEAR: len_in = '0;
               CMD_APPEND: begin
                  if (len_ff < LEN_W'(LIST_DEPTH)) begin
                     ctl.op = CELL_WRITE;
                     len_in = len_ff + 1'b1;
                  end
               end
               CMD_PREPEND: begin
                  ctl.op = CELL_SHUP;
                  if (len_ff < LEN_W'(LIST_DEPTH)) len_in = len_ff + 1'b1;
               end
               CMD_POP: begin
                  if (len_ff != '0) len_in = len_ff - 1'b1;
               end
               CMD_ERASE: begin
                  if (pos_ff < len_ff) begin
                     if (span_ff[9]) len_in = pos_ff;
                     else if (ff_reach < len_w) len_in = len_ff - LEN_W'(span_ff[8:0]);
                     else len_in = pos_ff;
                  end
               end
               CMD_PICK: begin
                  if (pos_ff < len_ff) begin
                     ctl.op        = CELL_WRITE;
                     ctl.wr_idx    = pos_ff;
                     ctl.new_entry = carry_ff;
                     out_in        = carry_ff;
                     ovalid_in     = 1'b1;
                  end
               end
               default: ctl.op = CELL_HOLD;
            endcase
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, 9'(len_ff), out_ff.score, 32'(out_ff.code), 9'(hit_ff)};
               rsp_user_in  = ovalid_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         steps_ff     <= steps_in;
      end
      cmd_ff      <= cmd_in;
      new_ff      <= new_in;
      pos_ff      <= pos_in;
      span_ff     <= span_in;
      end_ff      <= end_in;
      carry_ff    <= carry_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      out_ff      <= out_in;
      ovalid_ff   <= ovalid_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LIST_DEPTH))
      else $error("list length beyond depth");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (k_ff < steps_ff))
      else $error("step counter overran");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("command taken but engine stayed idle");

   a_len_only_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |=> $stable(len_ff))
      else $error("length moved during a chain pass");

endmodule

`default_nettype wire

[rtl/sele_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module sele_cell (
   input  wire                      clock,
   input  wire [sele_pkg::LEN_W-1:0] idx,
   input  wire sele_pkg::ctl_type   ctl,
   input  wire sele_pkg::entry_type left,
   input  wire sele_pkg::entry_type right,
   input  wire                      swap_l,
   output logic                     swap_r,
   output sele_pkg::entry_type      entry
);
   import sele_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;

   assign entry = ent_ff;

   always_comb begin
      swap_r = (ctl.op == CELL_SORT) && (idx >= ctl.pos) && (idx < ctl.sort_end)
               && (idx[0] == ctl.parity) && (ent_ff.score < right.score);
   end

   always_comb begin
      ent_in = ent_ff;
      unique case (ctl.op)
         CELL_HOLD: ent_in = ent_ff;
         CELL_WRITE: begin
            if (idx == ctl.wr_idx) ent_in = ctl.new_entry;
         end
         CELL_SHUP: ent_in = left;
         CELL_SHDN: begin
            if (idx >= ctl.pos) ent_in = right;
         end
         CELL_ROT: ent_in = right;
         CELL_SORT: begin
            if (swap_r) ent_in = right;
            else if (swap_l) ent_in = left;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import sele_pkg::*;

   typedef struct {
      bit             drain;
      cmd_type        cmd;
      logic [31:0]    code;
      logic [31:0]    score;
      logic [7:0]     pos;
      logic [9:0]     span;
   } req_item_type;

   typedef struct {
      logic [8:0]  hit;
      logic [31:0] code;
      logic [31:0] score;
      logic        valid;
      logic [8:0]  len;
   } list_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [3:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   scored_entry_list_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   req_item_type pending_q[$];
   list_rsp_type expected_q[$];
   logic [31:0] list_codes[LIST_DEPTH];
   logic [31:0] list_scores[LIST_DEPTH];
   int          list_len;
   int          errors, accepted, received, max_len_seen, full_hits;
   int          offered;
   int          cmd_count[16];
   bit          stim_done, hold_done;
   int          burst_left, gap_left, hold_left, stall_phase;
   logic [31:0] code_pool[16];

   initial begin
      clock = 0;
   end
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch on transfer %0d: %s got %h expected %h", received, what, got, want);
   endtask

   task automatic add_item(input req_item_type it);
      pending_q.insert(pending_q.size(), it);
   endtask

   // list model: work out the result of one command and update the list
   function automatic list_rsp_type apply_command(input logic [3:0] cmd,
                                                  input logic [31:0] code,
                                                  input logic [31:0] score, input int pos,
                                                  input logic [9:0] span_raw);
      list_rsp_type r;
      int          span, i, j, last, cnt;
      logic [31:0] c, s;
      r = '{default: '0};
      span = $signed(span_raw);
      case (cmd)
         CMD_CLEAR: list_len = 0;
         CMD_APPEND: begin
            if (list_len < LIST_DEPTH) begin
               list_codes[list_len] = code;
               list_scores[list_len] = score;
               list_len++;
            end
         end
         CMD_PREPEND: begin
            for (i = (list_len >= LIST_DEPTH ? LIST_DEPTH - 1 : list_len); i > 0; i--) begin
               list_codes[i] = list_codes[i-1];
               list_scores[i] = list_scores[i-1];
            end
            list_codes[0] = code;
            list_scores[0] = score;
            if (list_len < LIST_DEPTH) list_len++;
         end
         CMD_POP: if (list_len > 0) list_len--;
         CMD_ERASE: begin
            if (pos < list_len) begin
               if (span < 0) begin
                  list_len = pos;
               end else begin
                  cnt = span;
                  for (i = pos; i + cnt < list_len; i++) begin
                     list_codes[i] = list_codes[i+cnt];
                     list_scores[i] = list_scores[i+cnt];
                  end
                  list_len = (list_len - pos > cnt) ? list_len - cnt : pos;
               end
            end
         end
         CMD_FIND: begin
            for (i = 0; i < list_len; i++)
               if (list_codes[i] == code) break;
            r.hit = 9'(i);
         end
         CMD_READ: begin
            if (pos < list_len) begin
               r.valid = 1;
               r.code = list_codes[pos];
               r.score = list_scores[pos];
            end
         end
         CMD_SORT: begin
            if (list_len > 0) begin
               last = list_len - 1;
               if (span >= 0 && span < list_len) last = span;
               for (i = pos + 1; i <= last; i++) begin
                  c = list_codes[i];
                  s = list_scores[i];
                  j = i;
                  while (j > pos && $signed(list_scores[j-1]) < $signed(s)) begin
                     list_codes[j] = list_codes[j-1];
                     list_scores[j] = list_scores[j-1];
                     j--;
                  end
                  list_codes[j] = c;
                  list_scores[j] = s;
               end
            end
         end
         CMD_PICK: begin
            if (pos < list_len) begin
               for (i = pos + 1; i < list_len; i++) begin
                  if ($signed(list_scores[i]) > $signed(list_scores[pos])) begin
                     c = list_codes[pos];
                     s = list_scores[pos];
                     list_codes[pos] = list_codes[i];
                     list_scores[pos] = list_scores[i];
                     list_codes[i] = c;
                     list_scores[i] = s;
                  end
               end
               r.valid = 1;
               r.code = list_codes[pos];
               r.score = list_scores[pos];
            end
         end
         default: ;
      endcase
      r.len = 9'(list_len);
      return r;
   endfunction

   function automatic req_item_type mk(input cmd_type cmd, input logic [31:0] code,
                                       input logic [31:0] score, input int pos,
                                       input int span);
      req_item_type it;
      it.drain = 0;
      it.cmd = cmd;
      it.code = code;
      it.score = score;
      it.pos = pos[7:0];
      it.span = span[9:0];
      return it;
   endfunction

   function automatic req_item_type random_item(input int mode);
      req_item_type it;
      int        w;
      logic [31:0] sc;
      w = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
         0: sc = 32'h8000_0000;
         1: sc = 32'h7fff_ffff;
         2: sc = $urandom_range(0, 3) - 1;
         default: sc = $urandom;
      endcase
      it = mk(CMD_READ, ($urandom_range(0, 1) ? code_pool[$urandom_range(0, 15)] : $urandom),
              sc, ($urandom_range(0, 2) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 40)),
              ($urandom_range(0, 3) == 0 ? -1 :
               ($urandom_range(0, 5) == 0 ? $urandom_range(0, 256) : $urandom_range(0, 10))));
      if (mode == 1) begin
         if (w < 55) it.cmd = CMD_APPEND;
         else if (w < 75) it.cmd = CMD_PREPEND;
         else if (w < 82) it.cmd = CMD_FIND;
         else if (w < 90) it.cmd = CMD_READ;
         else if (w < 94) it.cmd = CMD_PICK;
         else if (w < 97) it.cmd = CMD_SORT;
         else it.cmd = CMD_POP;
      end else begin
         if (w < 2) it.cmd = CMD_CLEAR;
         else if (w < 22) it.cmd = CMD_APPEND;
         else if (w < 32) it.cmd = CMD_PREPEND;
         else if (w < 40) it.cmd = CMD_POP;
         else if (w < 48 + mode * 6) it.cmd = CMD_ERASE;
         else if (w < 62) it.cmd = CMD_FIND;
         else if (w < 74) it.cmd = CMD_READ;
         else if (w < 84) it.cmd = CMD_SORT;
         else if (w < 97) it.cmd = CMD_PICK;
         else it.cmd = cmd_type'(4'(CMD_PICK) + 4'($urandom_range(1, 7)));
      end
      return it;
   endfunction

   // stimulus
   initial begin
      req_item_type marker;
      marker = mk(CMD_CLEAR, 0, 0, 0, 0);
      marker.drain = 1;
      foreach (code_pool[k]) code_pool[k] = $urandom;
      add_item(mk(CMD_CLEAR, 0, 0, 0, 0));
      add_item(mk(CMD_POP, 0, 0, 0, 0));
      add_item(mk(CMD_READ, 0, 0, 0, 0));
      add_item(mk(CMD_PICK, 0, 0, 0, 0));
      add_item(mk(CMD_ERASE, 0, 0, 0, -1));
      add_item(mk(CMD_SORT, 0, 0, 0, -1));
      add_item(mk(CMD_APPEND, 32'hffff_ffff, 32'h7fff_ffff, 0, 0));
      add_item(mk(CMD_APPEND, 32'h0, 32'h8000_0000, 0, 0));
      add_item(mk(CMD_PREPEND, 32'ha5a5_a5a5, 32'h0, 0, 0));
      add_item(mk(CMD_APPEND, 32'h5a5a_5a5a, 32'h0, 0, 0));
      add_item(mk(CMD_APPEND, 32'h1234_5678, 32'h7fff_ffff, 0, 0));
      add_item(mk(CMD_FIND, 32'hffff_ffff, 0, 0, 0));
      add_item(mk(CMD_FIND, 32'hdead_beef, 0, 0, 0));
      add_item(mk(CMD_SORT, 0, 0, 0, -1));
      add_item(mk(CMD_READ, 0, 0, 1, 0));
      add_item(mk(CMD_READ, 0, 0, 255, 0));
      add_item(mk(CMD_PICK, 0, 0, 2, 0));
      add_item(mk(CMD_SORT, 0, 0, 255, 256));
      add_item(mk(CMD_ERASE, 0, 0, 1, 1));
      add_item(mk(CMD_ERASE, 0, 0, 255, 256));
      add_item(mk(CMD_ERASE, 0, 0, 1, 255));
      add_item(mk(CMD_PREPEND, 32'h0f0f_0f0f, 32'hffff_ffff, 0, 0));
      add_item(mk(CMD_ERASE, 0, 0, 1, -1));
      add_item(mk(CMD_FIND, 32'h0f0f_0f0f, 0, 0, 0));
      add_item(mk(cmd_type'(4'hf), 0, 0, 0, 0));
      add_item(marker);
      for (int seg = 0; seg < 6; seg++) begin
         for (int n = 0; n < 255; n++)
            add_item(random_item(seg % 3));
         add_item(marker);
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= '0;
         burst_left = 0;
         gap_left = 0;
      end else if (!(req_tvalid && accepted != offered)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 0;
         end else if (pending_q.size() == 0) begin
            req_tvalid <= 0;
            stim_done = 1;
         end else if (pending_q[0].drain) begin
            if (expected_q.size() == 0) void'(pending_q.pop_front());
            req_tvalid <= 0;
         end else begin
            req_item_type it;
            it = pending_q.pop_front();
            req_tdata <= {6'b0, it.span, it.pos, it.score, it.code};
            req_tuser <= it.cmd;
            req_tvalid <= 1;
            offered++;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 30);
               gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 300);
            end
         end
      end
   end

   // accepted requests feed the list model
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         accepted++;
         cmd_count[req_tuser]++;
         expected_q.insert(expected_q.size(),
                           apply_command(req_tuser, req_tdata[31:0], req_tdata[63:32],
                                         int'(req_tdata[71:64]), req_tdata[81:72]));
         if (list_len > max_len_seen) max_len_seen = list_len;
         if (list_len == LIST_DEPTH) full_hits++;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         hold_left = 0;
         stall_phase = 0;
      end else begin
         stall_phase++;
         if (!hold_done && accepted >= 400) begin
            hold_done = 1;
            hold_left = 2000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else if ((stall_phase / 700) % 2 == 0) begin
            rsp_tready <= 1;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         list_rsp_type want;
         received++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("unexpected response transfer %0d", received);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[8:0] !== want.hit)
               report("hit_index", 32'(rsp_tdata[8:0]), 32'(want.hit));
            if (rsp_tdata[40:9] !== want.code) report("code", rsp_tdata[40:9], want.code);
            if (rsp_tdata[72:41] !== want.score) report("score", rsp_tdata[72:41], want.score);
            if (rsp_tuser[0] !== want.valid)
               report("out_valid", 32'(rsp_tuser[0]), 32'(want.valid));
            if (rsp_tdata[81:73] !== want.len)
               report("length", 32'(rsp_tdata[81:73]), 32'(want.len));
         end
      end
   end

   initial begin
      reset = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      wait (stim_done && pending_q.size() == 0);
      wait (expected_q.size() == 0);
      repeat (LIST_DEPTH + 20) @(posedge clock);
      $display("%0d commands, %0d responses; full list reached %0d times, longest %0d",
               accepted, received, full_hits, max_len_seen);
      $display("clear %0d append %0d prepend %0d pop %0d erase %0d find %0d read %0d sort %0d pick %0d",
               cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
               cmd_count[5], cmd_count[6], cmd_count[7], cmd_count[8]);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[scored_entry_list_engine_unit.f]
rtl/sele_pkg.sv
rtl/sele_cell.sv
rtl/scored_entry_list_engine_unit.sv
tb/sv/testbench.sv
